// ===== sv/tcqd_pkg.sv =====
// Shared types and constants for the task cycle quiescence detector.
// No dependencies; used by tcqd_ctrl, tcqd_dp and task_cycle_quiescence_detector.
package tcqd_pkg;

  localparam int unsigned BUSY_W = 5;

  typedef enum logic [2:0] {
    ACT_BEGIN   = 3'd0,
    ACT_END     = 3'd1,
    ACT_CREATE  = 3'd2,
    ACT_DESTROY = 3'd3,
    ACT_BLOCK   = 3'd4,
    ACT_UNBLOCK = 3'd5
  } tcqd_action_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } tcqd_state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } tcqd_cmd_t;

endpackage

// ===== sv/tcqd_ctrl.sv =====
// Transaction sequencer of the quiescence detector: handshake and datapath commands.
// Depends on tcqd_pkg.
module tcqd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcqd_pkg::tcqd_cmd_t cmd_o
);

  tcqd_pkg::tcqd_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      tcqd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tcqd_pkg::ST_EXEC;
        end
      end
      tcqd_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = tcqd_pkg::ST_RESP;
      end
      tcqd_pkg::ST_RESP: begin
        if (!out_stall_i) begin
          state_d = tcqd_pkg::ST_IDLE;
        end
      end
      default: state_d = tcqd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcqd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != tcqd_pkg::ST_IDLE);
  assign out_valid_o = (state_q == tcqd_pkg::ST_RESP);

endmodule

// ===== sv/tcqd_dp.sv =====
// Datapath of the quiescence detector: per-thread memory, global counters, result registers.
// Depends on tcqd_pkg; driven by commands from tcqd_ctrl.
module tcqd_dp #(
  parameter int THREADS    = 16,
  parameter int COUNT_BITS = 16,
  parameter int NEST_MAX   = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcqd_pkg::tcqd_cmd_t          cmd_i,
  input  logic [2:0]                   action_i,
  input  logic [3:0]                   thread_id_i,
  output logic                         cycle_detected_o,
  output logic                         cycle_repeat_o,
  output logic                         work_complete_o,
  output logic                         nesting_error_o,
  output logic [tcqd_pkg::BUSY_W-1:0]  busy_threads_o
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int DW = $clog2(NEST_MAX + 1);

  logic [DW-1:0]         depth_mem [THREADS];
  logic [COUNT_BITS-1:0] lbd_mem   [THREADS];
  logic [COUNT_BITS-1:0] lud_mem   [THREADS];
  logic [THREADS-1:0]    vld_q;

  logic [7:0]    tid_ext;
  logic [TW-1:0] idx_in;
  logic          inrange_in;

  tcqd_pkg::tcqd_action_e act_q;
  logic [TW-1:0]          idx_q;
  logic                   inrange_q;
  logic                   rd_vld_q;
  logic [DW-1:0]          rd_depth_q;
  logic [COUNT_BITS-1:0]  rd_lbd_q, rd_lud_q;

  logic [tcqd_pkg::BUSY_W-1:0] busy_q, busy_d;
  logic [COUNT_BITS-1:0]       gu_q, gu_d, gb_q, gb_d;
  logic                        seen_q, seen_d;

  logic [DW-1:0]         depth, depth_d;
  logic [COUNT_BITS-1:0] lbd, lud;
  logic [COUNT_BITS-1:0] lbd_d, lud_d;
  logic                  cyc, rep, done, nerr;

  logic                        cyc_q, rep_q, done_q, nerr_q;
  logic [tcqd_pkg::BUSY_W-1:0] busy_out_q;

  assign tid_ext    = 8'(thread_id_i);
  assign idx_in     = tid_ext[TW-1:0];
  assign inrange_in = (32'(thread_id_i) < 32'(THREADS));

  // sample transaction and read the thread entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q      <= tcqd_pkg::tcqd_action_e'(action_i);
      idx_q      <= idx_in;
      inrange_q  <= inrange_in;
      rd_vld_q   <= inrange_in && vld_q[idx_in];
      rd_depth_q <= depth_mem[idx_in];
      rd_lbd_q   <= lbd_mem[idx_in];
      rd_lud_q   <= lud_mem[idx_in];
    end
  end

  always_comb begin
    depth   = rd_vld_q ? rd_depth_q : '0;
    lbd     = rd_vld_q ? rd_lbd_q : '0;
    lud     = rd_vld_q ? rd_lud_q : '0;
    depth_d = depth;
    lbd_d   = lbd;
    lud_d   = lud;
    busy_d  = busy_q;
    gu_d    = gu_q;
    gb_d    = gb_q;
    seen_d  = seen_q;
    cyc     = 1'b0;
    rep     = 1'b0;
    done    = 1'b0;
    nerr    = 1'b0;
    if (inrange_q) begin
      unique case (act_q)
        tcqd_pkg::ACT_BEGIN: begin
          if (depth < DW'(NEST_MAX)) begin
            depth_d = depth + DW'(1);
            if (depth == '0) begin
              busy_d = busy_q + tcqd_pkg::BUSY_W'(1);
              lbd_d  = '0;
              lud_d  = '0;
            end
          end
        end
        tcqd_pkg::ACT_END: begin
          if (depth == '0) begin
            nerr = 1'b1;
          end else begin
            depth_d = depth - DW'(1);
            if (depth == DW'(1)) begin
              gb_d   = gb_q + lbd;
              gu_d   = gu_q + lud;
              busy_d = busy_q - tcqd_pkg::BUSY_W'(1);
              if (busy_d == '0 && gu_d == '0) begin
                if (gb_d != '0) begin
                  cyc    = 1'b1;
                  rep    = seen_q;
                  seen_d = 1'b1;
                end else begin
                  done = 1'b1;
                end
              end
            end
          end
        end
        tcqd_pkg::ACT_CREATE:  lud_d = lud + COUNT_BITS'(1);
        tcqd_pkg::ACT_DESTROY: lud_d = lud - COUNT_BITS'(1);
        tcqd_pkg::ACT_BLOCK: begin
          lbd_d = lbd + COUNT_BITS'(1);
          lud_d = lud - COUNT_BITS'(1);
        end
        tcqd_pkg::ACT_UNBLOCK: begin
          lud_d = lud + COUNT_BITS'(1);
          lbd_d = lbd - COUNT_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  // write back the thread entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && inrange_q) begin
      depth_mem[idx_q] <= depth_d;
      lbd_mem[idx_q]   <= lbd_d;
      lud_mem[idx_q]   <= lud_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      busy_q <= '0;
      gu_q   <= '0;
      gb_q   <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.exec) begin
      if (inrange_q) begin
        vld_q[idx_q] <= 1'b1;
      end
      busy_q <= busy_d;
      gu_q   <= gu_d;
      gb_q   <= gb_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cyc_q      <= cyc;
      rep_q      <= rep;
      done_q     <= done;
      nerr_q     <= nerr;
      busy_out_q <= busy_d;
    end
  end

  assign cycle_detected_o = cyc_q;
  assign cycle_repeat_o   = rep_q;
  assign work_complete_o  = done_q;
  assign nesting_error_o  = nerr_q;
  assign busy_threads_o   = busy_out_q;

endmodule

// ===== sv/task_cycle_quiescence_detector.sv =====
// Top level of the task cycle quiescence detector: sequencer plus datapath.
// Depends on tcqd_pkg, tcqd_ctrl and tcqd_dp.
//
// Tracks worker threads' busy nesting and task deltas, and on each outermost
// end busy reports either completion or a dependency cycle once no thread is
// busy and no task is unblocked. Every transaction yields exactly one result.
// A transaction runs as accept and read of the per-thread entry
// from the thread memory, update of that entry and the global counters, then
// the result register, held until taken. A new transaction is accepted in the
// cycle after the result is taken, so only one transaction is in flight at a
// time. Per-thread state is three arrays (nesting depth, blocked and unblocked
// task deltas) with a valid bit per thread; reset needs no clearing pass.
module task_cycle_quiescence_detector #(
  parameter int THREADS    = 16,
  parameter int COUNT_BITS = 16,
  parameter int NEST_MAX   = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   action_i,
  input  logic [3:0]                   thread_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         cycle_detected_o,
  output logic                         cycle_repeat_o,
  output logic                         work_complete_o,
  output logic                         nesting_error_o,
  output logic [tcqd_pkg::BUSY_W-1:0]  busy_threads_o
);

  tcqd_pkg::tcqd_cmd_t cmd;

  tcqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tcqd_dp #(
    .THREADS    (THREADS),
    .COUNT_BITS (COUNT_BITS),
    .NEST_MAX   (NEST_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .thread_id_i      (thread_id_i),
    .cycle_detected_o (cycle_detected_o),
    .cycle_repeat_o   (cycle_repeat_o),
    .work_complete_o  (work_complete_o),
    .nesting_error_o  (nesting_error_o),
    .busy_threads_o   (busy_threads_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##1 out_valid_o)
    else $error("result missing two cycles after a transaction");

  a_outcome_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cycle_detected_o && work_complete_o) &&
                    !(cycle_repeat_o && !cycle_detected_o))
    else $error("conflicting quiescence outcome");

  a_error_no_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && nesting_error_o) |-> !cycle_detected_o && !work_complete_o)
    else $error("nesting error reported with an outcome");

endmodule
